[sv/small_key_value_store_assert.svh]
// Assertion macros for the key-value table. Each takes a label, a property
// and a message, and samples on the rising edge of clk.
`ifndef SMALL_KEY_VALUE_STORE_ASSERT_SVH
`define SMALL_KEY_VALUE_STORE_ASSERT_SVH

`ifndef SYNTHESIS
`define KVS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define KVS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KVS_ASSERT(label, prop, msg)
`define KVS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[sv/kvs_pkg.sv]
`default_nettype none

package kvs_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_DIGITS_DEF = 8;

	localparam int VALUE_W = 8;
	localparam int CAP_W   = 5;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

	// Word index of the capacity register within the APB window.
	localparam logic [0:0] REG_CAPACITY = 1'b0;

	typedef enum logic {
		OP_SET = 1'b0,
		OP_GET = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_UPDATED  = 3'd0,
		ST_INSERTED = 3'd1,
		ST_DROPPED  = 3'd2,
		ST_HIT      = 3'd3,
		ST_MISS     = 3'd4
	} status_t;

	// Control part of the lookup token that walks down the row of cells.
	typedef struct packed {
		logic    active;
		opcode_t opcode;
		logic    hit;
	} tok_ctl_t;

endpackage

`default_nettype wire

[sv/kvs_if.sv]
`default_nettype none

interface kvs_req_if #(
	parameter int KEY_DIGITS = kvs_pkg::KEY_DIGITS_DEF
);
	import kvs_pkg::*;

	localparam int LenW = $clog2(KEY_DIGITS + 1);

	logic                  valid;
	logic                  ready;
	opcode_t               opcode;
	logic [KEY_DIGITS-1:0] key_bits;
	logic [LenW-1:0]       key_length;
	logic [VALUE_W-1:0]    value_byte;

	modport source (output valid, output opcode, output key_bits, output key_length,
		output value_byte, input ready);
	modport sink (input valid, input opcode, input key_bits, input key_length,
		input value_byte, output ready);
endinterface

interface kvs_rsp_if;
	import kvs_pkg::*;

	logic               valid;
	logic               ready;
	status_t            status;
	logic [VALUE_W-1:0] read_value;

	modport source (output valid, output status, output read_value, input ready);
	modport sink (input valid, input status, input read_value, output ready);
endinterface

`default_nettype wire

[sv/kvs_cell.sv]
`default_nettype none

module kvs_cell #(
	parameter int KEY_DIGITS = kvs_pkg::KEY_DIGITS_DEF
) (
	input  wire                                         clk,
	input  wire                                         arst_n,
	input  wire                                         filled,
	input  wire kvs_pkg::tok_ctl_t                      ctl_i,
	input  wire [KEY_DIGITS-1:0]                        digits_i,
	input  wire [$clog2(KEY_DIGITS+1)-1:0]              len_i,
	input  wire [kvs_pkg::VALUE_W-1:0]                  value_i,
	input  wire [kvs_pkg::VALUE_W-1:0]                  rd_i,
	output kvs_pkg::tok_ctl_t                           ctl_o,
	output logic [KEY_DIGITS-1:0]                       digits_o,
	output logic [$clog2(KEY_DIGITS+1)-1:0]             len_o,
	output logic [kvs_pkg::VALUE_W-1:0]                 value_o,
	output logic [kvs_pkg::VALUE_W-1:0]                 rd_o,
	input  wire                                         ins_en,
	input  wire [KEY_DIGITS-1:0]                        ins_digits,
	input  wire [$clog2(KEY_DIGITS+1)-1:0]              ins_len,
	input  wire [kvs_pkg::VALUE_W-1:0]                  ins_value
);
	import kvs_pkg::*;

	localparam int LenW = $clog2(KEY_DIGITS + 1);

	logic [KEY_DIGITS-1:0] key_digits_q;
	logic [LenW-1:0]       key_len_q;
	logic [VALUE_W-1:0]    entry_value_q;
	tok_ctl_t              ctl_q;
	logic [KEY_DIGITS-1:0] digits_q;
	logic [LenW-1:0]       len_q;
	logic [VALUE_W-1:0]    value_q;
	logic [VALUE_W-1:0]    rd_q;
	logic                  match;

	// Only the first matching entry along the row answers.
	assign match = ctl_i.active && filled && !ctl_i.hit &&
		(key_len_q == len_i) && (key_digits_q == digits_i);

	always_ff @(posedge clk) begin
		if (ins_en) begin
			key_digits_q  <= ins_digits;
			key_len_q     <= ins_len;
			entry_value_q <= ins_value;
		end else if (match && ctl_i.opcode == OP_SET) begin
			entry_value_q <= value_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.active <= ctl_i.active;
			ctl_q.opcode <= ctl_i.opcode;
			ctl_q.hit    <= ctl_i.hit || match;
		end
	end

	always_ff @(posedge clk) begin
		digits_q <= digits_i;
		len_q    <= len_i;
		value_q  <= value_i;
		rd_q     <= match ? entry_value_q : rd_i;
	end

	assign ctl_o    = ctl_q;
	assign digits_o = digits_q;
	assign len_o    = len_q;
	assign value_o  = value_q;
	assign rd_o     = rd_q;

endmodule

`default_nettype wire

[sv/small_key_value_store.sv]
// An accepted transaction passes through the ENTRIES cell registers, then the fin register,
// then the output register before its result handshake. The lookup token walks the row of
// ENTRIES cells one cell per cycle, and the next transaction waits until the result has
// moved into the output register.
// Reset: capacity returns to 16, the fill count to zero and the cell row is emptied of tokens.
// Stored keys and values are not cleared; entries beyond the fill count are never searched.
`default_nettype none
`include "small_key_value_store_assert.svh"

module small_key_value_store #(
	parameter int ENTRIES    = kvs_pkg::ENTRIES_DEF,
	parameter int KEY_DIGITS = kvs_pkg::KEY_DIGITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [kvs_pkg::PADDR_W-1:0]   paddr,
	input  wire [kvs_pkg::PDATA_W-1:0]   pwdata,
	output logic [kvs_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	kvs_req_if.sink                      req,
	kvs_rsp_if.source                    rsp
);
	import kvs_pkg::*;

	localparam int LenW   = $clog2(KEY_DIGITS + 1);
	localparam int CountW = $clog2(ENTRIES + 1);

	logic [CAP_W-1:0]      capacity_q;
	logic [CountW-1:0]     count_q;
	logic                  busy_q;
	logic                  fin_valid_q;
	status_t               fin_status_q;
	logic [VALUE_W-1:0]    fin_rd_q;
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [VALUE_W-1:0]    out_rd_q;

	tok_ctl_t              ctl_c    [0:ENTRIES];
	logic [KEY_DIGITS-1:0] digits_c [0:ENTRIES];
	logic [LenW-1:0]       len_c    [0:ENTRIES];
	logic [VALUE_W-1:0]    value_c  [0:ENTRIES];
	logic [VALUE_W-1:0]    rd_c     [0:ENTRIES];

	logic [ENTRIES-1:0]    active_vec;
	logic [LenW-1:0]       len_sat;
	logic [KEY_DIGITS-1:0] digit_mask;
	logic                  req_fire;
	logic                  tail_active;
	logic                  tail_hit;
	logic                  room;
	logic                  ins_any;
	logic                  move;
	status_t               tail_status;
	logic [VALUE_W-1:0]    tail_rd;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// Key normalization: saturate the length and drop digits above it.
	assign len_sat = (req.key_length > LenW'(KEY_DIGITS)) ? LenW'(KEY_DIGITS) : req.key_length;

	always_comb begin
		for (int b = 0; b < KEY_DIGITS; b++) begin
			digit_mask[b] = (LenW'(b) < len_sat);
		end
	end

	assign req.ready = !busy_q;
	assign req_fire  = req.valid && req.ready;

	assign ctl_c[0].active = req_fire;
	assign ctl_c[0].opcode = req.opcode;
	assign ctl_c[0].hit    = 1'b0;
	assign digits_c[0]     = req.key_bits & digit_mask;
	assign len_c[0]        = len_sat;
	assign value_c[0]      = req.value_byte;
	assign rd_c[0]         = '0;

	// Tail of the row: decide the outcome and place a new entry if needed.
	assign tail_active = ctl_c[ENTRIES].active;
	assign tail_hit    = ctl_c[ENTRIES].hit;
	assign room        = (32'(count_q) < 32'(capacity_q)) && (32'(count_q) < ENTRIES);
	assign ins_any     = tail_active && ctl_c[ENTRIES].opcode == OP_SET && !tail_hit && room;

	always_comb begin
		tail_rd = '0;
		case (ctl_c[ENTRIES].opcode)
			OP_SET: begin
				if (tail_hit) begin
					tail_status = ST_UPDATED;
				end else if (room) begin
					tail_status = ST_INSERTED;
				end else begin
					tail_status = ST_DROPPED;
				end
			end
			OP_GET: begin
				if (tail_hit) begin
					tail_status = ST_HIT;
					tail_rd     = rd_c[ENTRIES];
				end else begin
					tail_status = ST_MISS;
				end
			end
			default: begin
				tail_status = ST_MISS;
			end
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
			kvs_cell #(
				.KEY_DIGITS(KEY_DIGITS)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.filled    (CountW'(gi) < count_q),
				.ctl_i     (ctl_c[gi]),
				.digits_i  (digits_c[gi]),
				.len_i     (len_c[gi]),
				.value_i   (value_c[gi]),
				.rd_i      (rd_c[gi]),
				.ctl_o     (ctl_c[gi+1]),
				.digits_o  (digits_c[gi+1]),
				.len_o     (len_c[gi+1]),
				.value_o   (value_c[gi+1]),
				.rd_o      (rd_c[gi+1]),
				.ins_en    (ins_any && count_q == CountW'(gi)),
				.ins_digits(digits_c[ENTRIES]),
				.ins_len   (len_c[ENTRIES]),
				.ins_value (value_c[ENTRIES])
			);
			assign active_vec[gi] = ctl_c[gi+1].active;
		end
	endgenerate

	// The finished result waits in fin until the output register is free.
	assign move = fin_valid_q && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			fin_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ins_any) begin
				count_q <= count_q + 1'b1;
			end
			if (req_fire) begin
				busy_q <= 1'b1;
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (tail_active) begin
				fin_valid_q <= 1'b1;
			end else if (move) begin
				fin_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail_active) begin
			fin_status_q <= tail_status;
			fin_rd_q     <= tail_rd;
		end
		if (move) begin
			out_status_q <= fin_status_q;
			out_rd_q     <= fin_rd_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.read_value = out_rd_q;

	`KVS_ASSERT(a_single_token, $onehot0(active_vec), "more than one lookup token in the row")
	`KVS_ASSERT(a_token_busy, (tail_active || fin_valid_q) |-> busy_q, "result pending while idle")
	`KVS_ASSERT(a_insert_count, ins_any |=> (count_q == $past(count_q) + 1'b1),
		"fill count did not advance on insert")
	`KVS_ASSERT_ALWAYS(a_count_bound, 32'(count_q) <= ENTRIES, "fill count beyond table size")

endmodule

`default_nettype wire

[tb/small_key_value_store_checker.sv]
`timescale 1ns / 1ps

module small_key_value_store_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [kvs_pkg::PADDR_W-1:0] paddr,
	input  logic [kvs_pkg::PDATA_W-1:0] pwdata,
	input  logic                        pready,
	kvs_req_if                          req,
	kvs_rsp_if                          rsp,
	output int                          failures,
	output int                          outstanding
);
	import kvs_pkg::*;

	localparam int TABLE_DEPTH = ENTRIES_DEF;
	localparam int KEY_MAX     = KEY_DIGITS_DEF;
	localparam int LEN_W       = $clog2(KEY_DIGITS_DEF + 1);
	localparam int MAX_PRINTED = 40;
	localparam int FIFO_DEPTH  = 64;

	typedef struct packed {
		logic [LEN_W-1:0]          length;
		logic [KEY_DIGITS_DEF-1:0] digits;
	} table_key_t;

	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] read_value;
	} reply_t;

	logic [CAP_W-1:0]   capacity_reg;
	table_key_t         stored_key [TABLE_DEPTH];
	logic [VALUE_W-1:0] stored_value [TABLE_DEPTH];
	int                 filled;
	reply_t             expected_replies [FIFO_DEPTH];
	int                 head_idx;
	int                 tail_idx;
	int                 status_tally [5];

	task automatic report_mismatch(string detail);
		failures++;
		if (failures <= MAX_PRINTED)
			$display("[%0t] mismatch: %s", $time, detail);
	endtask

	// Applies one table access to the shadow table and returns the reply it should produce.
	function automatic reply_t access_table(opcode_t op, logic [KEY_DIGITS_DEF-1:0] bits,
			logic [LEN_W-1:0] len_field, logic [VALUE_W-1:0] val);
		table_key_t key;
		logic [KEY_DIGITS_DEF:0] mask;
		int limit;
		int idx;
		reply_t r;
		key.length = (len_field > KEY_MAX) ? LEN_W'(KEY_MAX) : len_field;
		mask = ({{KEY_DIGITS_DEF{1'b0}}, 1'b1} << key.length) - 1'b1;
		key.digits = bits & mask[KEY_DIGITS_DEF-1:0];
		limit = (capacity_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(capacity_reg);
		idx = -1;
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (idx < 0 && i < filled && stored_key[i] == key)
				idx = i;
		r.read_value = '0;
		if (op == OP_SET) begin
			if (idx >= 0) begin
				stored_value[idx] = val;
				r.status = ST_UPDATED;
			end else if (filled < limit) begin
				stored_key[filled] = key;
				stored_value[filled] = val;
				filled++;
				r.status = ST_INSERTED;
			end else begin
				r.status = ST_DROPPED;
			end
		end else if (idx >= 0) begin
			r.read_value = stored_value[idx];
			r.status = ST_HIT;
		end else begin
			r.status = ST_MISS;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		reply_t want;
		if (!arst_n) begin
			capacity_reg = CAPACITY_RESET;
			filled = 0;
			head_idx = 0;
			tail_idx = 0;
			outstanding = 0;
			failures = 0;
			foreach (status_tally[i])
				status_tally[i] = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY)
				capacity_reg = pwdata[CAP_W-1:0];
			// A result at this edge can never belong to a transaction accepted at the same edge.
			if (rsp.valid && rsp.ready) begin
				if (outstanding == 0) begin
					report_mismatch($sformatf("result with status %0d and no transaction pending",
						rsp.status));
				end else begin
					want = expected_replies[head_idx];
					head_idx = (head_idx + 1) % FIFO_DEPTH;
					outstanding--;
					status_tally[want.status]++;
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status expected %0d, got %0d",
							want.status, rsp.status));
					if (rsp.read_value !== want.read_value)
						report_mismatch($sformatf("read_value expected 0x%02h, got 0x%02h",
							want.read_value, rsp.read_value));
				end
			end
			if (req.valid && req.ready) begin
				if (outstanding >= FIFO_DEPTH) begin
					report_mismatch("too many transactions waiting for a result");
				end else begin
					expected_replies[tail_idx] = access_table(req.opcode, req.key_bits,
						req.key_length, req.value_byte);
					tail_idx = (tail_idx + 1) % FIFO_DEPTH;
					outstanding++;
				end
			end
		end
	end

endmodule

[tb/small_key_value_store_tb.sv]
`timescale 1ns / 1ps

module small_key_value_store_tb;
	import kvs_pkg::*;

	localparam int RESET_CYCLES = 7;
	localparam int MAX_WAIT     = 14;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = ENTRIES_DEF + 3 + 8;
	localparam int LIMIT_CYCLES = 400000;
	localparam int PHASE_ITEMS  = 205;
	localparam int PHASES       = 5;
	localparam int POOL_SIZE    = 24;
	localparam int LEN_W        = $clog2(KEY_DIGITS_DEF + 1);
	localparam logic [PADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
	// Word one of the register window holds no register.
	localparam logic [PADDR_W-1:0] SPARE_ADDR = CAPACITY_ADDR + 3'd4;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 failures;
	int                 outstanding;
	int                 cycle_count;
	int                 sent_count;
	int                 setting_count;
	bit                 send_burst;
	bit                 recv_burst;
	bit                 hold_request;
	logic [KEY_DIGITS_DEF-1:0] pool_bits [POOL_SIZE];
	logic [LEN_W-1:0]          pool_len [POOL_SIZE];

	kvs_req_if req_ch ();
	kvs_rsp_if rsp_ch ();

	small_key_value_store dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	small_key_value_store_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin : watchdog
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= LIMIT_CYCLES) begin
				$display("Timed out after %0d cycles with %0d results outstanding",
					cycle_count, outstanding);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Result side: a random stall before each result, or one long hold-off on request.
	initial begin : result_sink
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_request) begin
				stall = LONG_HOLD;
				hold_request = 1'b0;
			end else begin
				stall = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid)
				@(posedge clk);
		end
	end

	task automatic send_access(opcode_t op, logic [KEY_DIGITS_DEF-1:0] bits,
			logic [LEN_W-1:0] len, logic [VALUE_W-1:0] val);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.opcode     <= op;
		req_ch.key_bits   <= bits;
		req_ch.key_length <= len;
		req_ch.value_byte <= val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic wait_for_replies();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == CAPACITY_ADDR)
			setting_count++;
	endtask

	task automatic new_pool_key(int slot);
		pool_len[slot]  = LEN_W'($urandom_range(0, KEY_DIGITS_DEF));
		pool_bits[slot] = KEY_DIGITS_DEF'($urandom);
	endtask

	// Mostly keys from a small pool, with random stray digits and over-long lengths, so that
	// sets and gets keep hitting stored entries; the rest is unrelated noise.
	task automatic send_random_access();
		int pick;
		opcode_t op;
		logic [LEN_W-1:0] len;
		logic [KEY_DIGITS_DEF-1:0] bits;
		logic [KEY_DIGITS_DEF:0] mask;
		op = ($urandom_range(0, 99) < 55) ? OP_SET : OP_GET;
		if ($urandom_range(0, 99) < 12) begin
			send_access(op, KEY_DIGITS_DEF'($urandom), LEN_W'($urandom_range(0, 15)),
				VALUE_W'($urandom));
		end else begin
			pick = $urandom_range(0, POOL_SIZE - 1);
			len = pool_len[pick];
			mask = ({{KEY_DIGITS_DEF{1'b0}}, 1'b1} << len) - 1'b1;
			bits = (pool_bits[pick] & mask[KEY_DIGITS_DEF-1:0])
				| (KEY_DIGITS_DEF'($urandom) & ~mask[KEY_DIGITS_DEF-1:0]);
			if (len == KEY_DIGITS_DEF && $urandom_range(0, 1))
				len = LEN_W'($urandom_range(KEY_DIGITS_DEF + 1, 15));
			send_access(op, bits, len, VALUE_W'($urandom));
		end
	endtask

	initial begin : stimulus
		int phase_caps [PHASES];
		arst_n            = 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.opcode     <= OP_SET;
		req_ch.key_bits   <= '0;
		req_ch.key_length <= '0;
		req_ch.value_byte <= '0;
		send_burst   = 1'b0;
		recv_burst   = 1'b0;
		hold_request = 1'b0;
		sent_count    = 0;
		setting_count = 0;
		for (int i = 0; i < POOL_SIZE; i++)
			new_pool_key(i);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With no room at all, even the empty key is dropped.
		write_reg(CAPACITY_ADDR, 0);
		send_access(OP_SET, 8'hFF, 4'd0, 8'h11);
		send_access(OP_GET, 8'h00, 4'd0, 8'h00);
		wait_for_replies();

		// A write to the unused word must leave the capacity of two in place.
		write_reg(CAPACITY_ADDR, 2);
		write_reg(SPARE_ADDR, 0);
		send_access(OP_SET, 8'h05, 4'd3, 8'hFF);
		send_access(OP_SET, 8'h05, 4'd4, 8'h00);
		send_access(OP_GET, 8'hFD, 4'd3, 8'h00);
		send_access(OP_GET, 8'h05, 4'd4, 8'hFF);
		send_access(OP_SET, 8'hA5, 4'd8, 8'h3C);
		send_access(OP_GET, 8'h05, 4'd5, 8'h00);
		send_access(OP_SET, 8'h05, 4'd3, 8'h5A);
		send_access(OP_GET, 8'h05, 4'd3, 8'h00);
		wait_for_replies();

		// An oversized capacity acts as the full table; long keys saturate to eight digits.
		write_reg(CAPACITY_ADDR, 31);
		send_access(OP_SET, 8'hFF, 4'd15, 8'h81);
		send_access(OP_GET, 8'hFF, 4'd8, 8'h00);
		send_access(OP_GET, 8'hFF, 4'd9, 8'h00);
		send_access(OP_SET, 8'h00, 4'd0, 8'h7E);
		send_access(OP_GET, 8'hAA, 4'd0, 8'h00);
		send_access(OP_GET, 8'h01, 4'd1, 8'h00);
		send_access(OP_SET, 8'h00, 4'd1, 8'h01);
		send_access(OP_SET, 8'h01, 4'd1, 8'h80);
		wait_for_replies();

		// Lowered below the fill count: updates still land, inserts are dropped.
		write_reg(CAPACITY_ADDR, 1);
		send_access(OP_SET, 8'h01, 4'd1, 8'h33);
		send_access(OP_SET, 8'h03, 4'd2, 8'h44);
		send_access(OP_GET, 8'h00, 4'd1, 8'h00);
		wait_for_replies();

		phase_caps = '{3, $urandom_range(7, 12), 16, 0, 31};
		for (int p = 0; p < PHASES; p++) begin
			write_reg(CAPACITY_ADDR, phase_caps[p]);
			repeat (4) new_pool_key($urandom_range(0, POOL_SIZE - 1));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 50 == 0) begin
					send_burst = ($urandom_range(0, 3) == 0);
					recv_burst = ($urandom_range(0, 3) == 0);
				end
				// Hold results back while transactions keep coming, so the input backs up.
				if (p == 1 && n == 60)
					hold_request = 1'b1;
				if (p == 2 && n == 100)
					wait_for_replies();
				send_random_access();
			end
			wait_for_replies();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d transactions over %0d capacity settings, zero and oversized too.",
			sent_count, setting_count);
		$display("Outcomes: %0d updated, %0d inserted, %0d dropped, %0d hits, %0d misses.",
			chk.status_tally[ST_UPDATED], chk.status_tally[ST_INSERTED],
			chk.status_tally[ST_DROPPED], chk.status_tally[ST_HIT], chk.status_tally[ST_MISS]);
		if (failures == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
